### rtl/core/fcw_pkg.sv
// shared types, codes and helpers of the fat12 cluster chain walker
package fcw_pkg;

    // widths fixed by the item fields
    localparam int CLUSTER_W = 12;
    localparam int COUNT_W   = 13;
    localparam int UNIT_W    = 14;

    // command codes
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_START   = 2'd1;
    localparam logic [1:0] CMD_ADVANCE = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    // result status codes
    localparam logic [1:0] ST_VALID    = 2'd0;
    localparam logic [1:0] ST_END      = 2'd1;
    localparam logic [1:0] ST_ERROR    = 2'd2;
    localparam logic [1:0] ST_NO_CHAIN = 2'd3;

    // end of chain marker range starts here
    localparam logic [CLUSTER_W-1:0] END_LOW = 12'hff8;

    // reset value of the table size register
    localparam logic [UNIT_W-1:0] FAT_BYTES_RESET = 14'd6144;

    // 2^16 / 3 rounded up, exact for floor(n / 3) over 14 bit n
    localparam logic [14:0] RECIP_3 = 15'd21846;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_WRAP,
        S_WRITE,
        S_RD_LO,
        S_RD_HI,
        S_ENTRY,
        S_CHK_RANGE,
        S_CHK_LEN,
        S_START_CHK,
        S_OUT
    } fcw_state_t;

    // shared unit operations
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t             op;
        logic [UNIT_W-1:0]   a;
        logic [UNIT_W-1:0]   b;
    } alu_req_t;

    typedef struct packed {
        logic [UNIT_W-1:0]   res;
        logic                ge;    // a >= b, meaningful for ALU_SUB
    } alu_rsp_t;

    // cluster count of a table of n bytes: floor(n / 3) * 2, n at most 8192
    function automatic logic [COUNT_W-1:0] cluster_count(input logic [UNIT_W-1:0] n);
        logic [28:0] prod;
        logic [12:0] q;
        prod = 29'(n) * 29'(RECIP_3);
        q    = prod[28:16];
        return {q[11:0], 1'b0};
    endfunction

endpackage

### rtl/core/fcw_alu.sv
// shared add / subtract-compare unit used by the chain sequencer
module fcw_alu
    import fcw_pkg::*;
(
    input  alu_req_t req,
    output alu_rsp_t rsp
);

    logic [UNIT_W:0] sum;

    // one adder; subtraction by inverted operand and carry in
    always_comb begin
        if (req.op == ALU_SUB) begin
            sum = {1'b0, req.a} + {1'b0, ~req.b} + {{UNIT_W{1'b0}}, 1'b1};
        end else begin
            sum = {1'b0, req.a} + {1'b0, req.b};
        end
        rsp.res = sum[UNIT_W-1:0];
        rsp.ge  = sum[UNIT_W];
    end

endmodule

### rtl/core/fcw_fat_ram.sv
// single port byte store holding the allocation table
module fcw_fat_ram #(
    parameter int DEPTH = 8192
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [7:0]               wdata,
    output logic [7:0]               rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    // write or registered read, one access per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/fcw_seq.sv
// sequencer and datapath that loads the table and walks cluster chains
module fcw_seq
    import fcw_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // input transaction
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   in_command,
    input  logic [12:0]                  in_byte_addr,
    input  logic [7:0]                   in_byte_data,
    input  logic [CLUSTER_W-1:0]         in_start_cluster,
    // result transaction
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [CLUSTER_W-1:0]         out_cluster,
    output logic [1:0]                   out_status,
    // table size
    input  logic [UNIT_W-1:0]            fat_bytes,
    // shared unit
    output alu_req_t                     alu_req,
    input  alu_rsp_t                     alu_rsp,
    // table store
    output logic                         mem_we,
    output logic [$clog2(TABLE_BYTES)-1:0] mem_addr,
    output logic [7:0]                   mem_wdata,
    input  logic [7:0]                   mem_rdata
);

    localparam int AW = $clog2(TABLE_BYTES);
    localparam logic [UNIT_W-1:0] TABLE_SIZE = UNIT_W'(TABLE_BYTES);

    fcw_state_t state_reg, state_next;

    logic [1:0]           cmd_reg;
    logic [12:0]          addr_in_reg;
    logic [7:0]           data_reg;
    logic [CLUSTER_W-1:0] first_reg;

    logic [COUNT_W-1:0]   count_reg;
    logic                 fat_zero_reg;
    logic [UNIT_W-1:0]    at_reg;
    logic [7:0]           lo_reg;
    logic [CLUSTER_W-1:0] entry_reg;

    logic                 active_reg;
    logic [CLUSTER_W-1:0] cur_reg;
    logic [COUNT_W-1:0]   len_reg;

    logic [CLUSTER_W-1:0] res_cluster_reg;
    logic [1:0]           res_status_reg;
    logic                 out_valid_reg;
    logic [CLUSTER_W-1:0] out_cluster_reg;
    logic [1:0]           out_status_reg;

    logic [UNIT_W-1:0]    fat_clamped;
    logic                 out_free;
    logic [7:0]           hi_byte;

    assign fat_clamped = (fat_bytes > TABLE_SIZE) ? TABLE_SIZE : fat_bytes;
    assign out_free    = !out_valid_reg || out_ready;
    assign hi_byte     = mem_rdata;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                unique case (cmd_reg)
                    CMD_LOAD:    state_next = S_WRAP;
                    CMD_START:   state_next = S_START_CHK;
                    CMD_ADVANCE: state_next = active_reg ? S_WRAP : S_OUT;
                    default:     state_next = S_IDLE;
                endcase
            end
            S_WRAP: begin
                if (!alu_rsp.ge) begin
                    state_next = (cmd_reg == CMD_LOAD) ? S_WRITE : S_RD_LO;
                end
            end
            S_WRITE:     state_next = S_IDLE;
            S_RD_LO:     state_next = S_RD_HI;
            S_RD_HI:     state_next = S_ENTRY;
            S_ENTRY:     state_next = S_CHK_RANGE;
            S_CHK_RANGE: begin
                if (entry_reg >= END_LOW || alu_rsp.ge) begin
                    state_next = S_OUT;
                end else begin
                    state_next = S_CHK_LEN;
                end
            end
            S_CHK_LEN:   state_next = S_OUT;
            S_START_CHK: state_next = S_OUT;
            S_OUT: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    // unit requests, store access and handshake outputs
    always_comb begin
        alu_req   = '{op: ALU_ADD, a: '0, b: '0};
        mem_we    = 1'b0;
        mem_addr  = at_reg[AW-1:0];
        mem_wdata = data_reg;
        in_ready  = 1'b0;
        unique case (state_reg)
            S_IDLE: in_ready = 1'b1;
            S_PREP: begin
                // byte offset of the entry: c + c/2
                alu_req = '{op: ALU_ADD,
                            a: UNIT_W'(cur_reg),
                            b: UNIT_W'(cur_reg >> 1)};
            end
            S_WRAP: begin
                alu_req = '{op: ALU_SUB, a: at_reg, b: TABLE_SIZE};
            end
            S_WRITE: mem_we = 1'b1;
            S_RD_LO: begin
                alu_req = '{op: ALU_ADD, a: at_reg, b: UNIT_W'(1)};
            end
            S_CHK_RANGE: begin
                alu_req = '{op: ALU_SUB, a: UNIT_W'(entry_reg), b: UNIT_W'(count_reg)};
            end
            S_CHK_LEN: begin
                alu_req = '{op: ALU_SUB, a: UNIT_W'(count_reg), b: UNIT_W'(len_reg)};
            end
            S_START_CHK: begin
                alu_req = '{op: ALU_SUB, a: UNIT_W'(count_reg), b: UNIT_W'(first_reg)};
            end
            default: begin
                alu_req = '{op: ALU_ADD, a: '0, b: '0};
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            active_reg    <= 1'b0;
            cur_reg       <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // taken result drops, unless a new one is loaded below
            if (out_valid_reg && out_ready && state_reg != S_OUT) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CHK_RANGE: begin
                    if (entry_reg >= END_LOW || alu_rsp.ge) begin
                        active_reg <= 1'b0;
                    end
                end
                S_CHK_LEN: begin
                    if (!alu_rsp.ge) begin
                        active_reg <= 1'b0;
                    end else begin
                        cur_reg <= entry_reg;
                        len_reg <= len_reg + COUNT_W'(1);
                    end
                end
                S_START_CHK: begin
                    if (fat_zero_reg || !alu_rsp.ge) begin
                        active_reg <= 1'b0;
                    end else begin
                        active_reg <= 1'b1;
                        cur_reg    <= first_reg;
                        len_reg    <= COUNT_W'(1);
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        out_valid_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: begin
                cmd_reg     <= in_command;
                addr_in_reg <= in_byte_addr;
                data_reg    <= in_byte_data;
                first_reg   <= in_start_cluster;
            end
            S_PREP: begin
                count_reg    <= cluster_count(fat_clamped);
                fat_zero_reg <= (fat_bytes == '0);
                if (cmd_reg == CMD_LOAD) begin
                    at_reg <= UNIT_W'(addr_in_reg);
                end else begin
                    at_reg <= alu_rsp.res;
                end
                res_cluster_reg <= '0;
                res_status_reg  <= ST_NO_CHAIN;
            end
            S_WRAP: begin
                if (alu_rsp.ge) begin
                    at_reg <= alu_rsp.res;
                end
            end
            S_RD_LO: begin
                // address of the upper byte, wrapped at the table end
                at_reg <= (alu_rsp.res == TABLE_SIZE) ? '0 : alu_rsp.res;
            end
            S_RD_HI: lo_reg <= mem_rdata;
            S_ENTRY: begin
                if (cur_reg[0]) begin
                    entry_reg <= {hi_byte, lo_reg[7:4]};
                end else begin
                    entry_reg <= {hi_byte[3:0], lo_reg};
                end
            end
            S_CHK_RANGE: begin
                res_cluster_reg <= entry_reg;
                res_status_reg  <= (entry_reg >= END_LOW) ? ST_END : ST_ERROR;
            end
            S_CHK_LEN: begin
                res_cluster_reg <= entry_reg;
                res_status_reg  <= alu_rsp.ge ? ST_VALID : ST_ERROR;
            end
            S_START_CHK: begin
                res_cluster_reg <= first_reg;
                res_status_reg  <= (fat_zero_reg || !alu_rsp.ge) ? ST_ERROR : ST_VALID;
            end
            S_OUT: begin
                if (out_free) begin
                    out_cluster_reg <= res_cluster_reg;
                    out_status_reg  <= res_status_reg;
                end
            end
            default: begin
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign out_cluster = out_cluster_reg;
    assign out_status  = out_status_reg;

endmodule

### rtl/core/fat12_cluster_chain_walker_core.sv
// top level of the fat12 cluster chain walker
// Holds a FAT12 allocation table of TABLE_BYTES bytes in a single-port store,
// loaded one byte per transaction, and follows cluster chains through it.
// Commands travel in s_tuser: load byte, start chain, advance. A start or an
// advance gives one result transaction (cluster in m_tdata, status in
// m_tuser); a load or the unused command gives none. Every transaction runs
// on a small sequencer around one shared add/compare unit and the store port,
// and the block takes no new transaction meanwhile. The byte address is wrapped
// by repeated table-size subtractions, none being needed when TABLE_BYTES is
// 8192. A result shows on m_tvalid as the block turns idle again; the
// sequencer waits in its output state for as long as an earlier result still
// waits on m_tready. The store has no reset and needs no clearing pass; only
// written bytes may be read. cfg_data (table size in bytes) may be written
// only while the block is idle.
module fat12_cluster_chain_walker_core
    import fcw_pkg::*;
#(
    parameter int TABLE_BYTES = 8192
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input transactions
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // byte_addr[12:0], byte_data[20:13], start_cluster[32:21]
    input  logic [1:0]  s_tuser,   // command[1:0]
    // result transactions
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // cluster[11:0]
    output logic [1:0]  m_tuser,   // status[1:0]
    // table size register
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [13:0] cfg_data
);

    localparam int AW = $clog2(TABLE_BYTES);

    logic [UNIT_W-1:0]    fat_bytes_reg;
    alu_req_t             alu_req;
    alu_rsp_t             alu_rsp;
    logic                 mem_we;
    logic [AW-1:0]        mem_addr;
    logic [7:0]           mem_wdata;
    logic [7:0]           mem_rdata;
    logic [CLUSTER_W-1:0] out_cluster;

    // table size register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fat_bytes_reg <= FAT_BYTES_RESET;
        end else if (cfg_valid) begin
            fat_bytes_reg <= cfg_data;
        end
    end

    fcw_seq #(
        .TABLE_BYTES (TABLE_BYTES)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_command       (s_tuser),
        .in_byte_addr     (s_tdata[12:0]),
        .in_byte_data     (s_tdata[20:13]),
        .in_start_cluster (s_tdata[32:21]),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .out_cluster      (out_cluster),
        .out_status       (m_tuser),
        .fat_bytes        (fat_bytes_reg),
        .alu_req          (alu_req),
        .alu_rsp          (alu_rsp),
        .mem_we           (mem_we),
        .mem_addr         (mem_addr),
        .mem_wdata        (mem_wdata),
        .mem_rdata        (mem_rdata)
    );

    fcw_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    fcw_fat_ram #(
        .DEPTH (TABLE_BYTES)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // result payload, upper bits zero
    assign m_tdata = {4'b0, out_cluster};

endmodule

### test/tb_fat12_cluster_chain_walker_core.sv
// self-checking testbench for the fat12 cluster chain walker core
module tb_fat12_cluster_chain_walker_core
    import fcw_pkg::*;
();

    localparam int unsigned STORE_BYTES = 8192;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [12:0] addr;
        logic [7:0]  data;
        logic [11:0] first;
    } walk_item_t;

    typedef struct packed {
        logic [11:0] cluster;
        logic [1:0]  status;
    } walk_result_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;    // byte_addr[12:0], byte_data[20:13], start_cluster[32:21]
    logic [1:0]  s_tuser   = '0;    // command[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [15:0] m_tdata;           // cluster[11:0]
    logic [1:0]  m_tuser;           // status[1:0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [13:0] cfg_data  = '0;

    fat12_cluster_chain_walker_core u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    // shadow of the block state
    logic [7:0]   fat_mem [STORE_BYTES];
    bit           fat_set [STORE_BYTES];
    logic [11:0]  cur_clu   = '0;
    logic [12:0]  walk_len  = '0;
    bit           walk_open = 1'b0;
    logic [13:0]  tbl_bytes = FAT_BYTES_RESET;

    walk_item_t   pending [$];
    walk_result_t walk_results_due [$];
    walk_item_t   launch_item;
    walk_result_t want_res;
    walk_result_t got_res;
    int unsigned  items_made    = 0;
    int unsigned  mismatches    = 0;
    int unsigned  send_gap_pct  = 0;
    int unsigned  sink_stall_pct = 0;

    // number of clusters the table in use can describe
    function automatic int unsigned cluster_limit(logic [13:0] n);
        int unsigned used;
        used = (n > STORE_BYTES) ? STORE_BYTES : n;
        return used / 3 * 2;
    endfunction

    function automatic int unsigned entry_at(logic [11:0] c);
        return ((3 * int'(c)) / 2) % STORE_BYTES;
    endfunction

    // unpack the 12 bit entry of a cluster from the shadow table
    function automatic logic [11:0] entry_of(logic [11:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = fat_mem[entry_at(c)];
        hi = fat_mem[(entry_at(c) + 1) % STORE_BYTES];
        if (c[0])
            return {hi, lo[7:4]};
        return {hi[3:0], lo};
    endfunction

    // update the shadow state and queue the item and its expected result
    task automatic walk_step(walk_item_t it);
        walk_result_t r;
        int unsigned  lim;
        logic [11:0]  nxt;
        lim = cluster_limit(tbl_bytes);
        case (it.cmd)
            CMD_LOAD: begin
                fat_mem[it.addr] = it.data;
                fat_set[it.addr] = 1'b1;
            end
            CMD_START: begin
                r.cluster = it.first;
                if (tbl_bytes == 0 || it.first > lim) begin
                    walk_open = 1'b0;
                    r.status  = ST_ERROR;
                end else begin
                    walk_open = 1'b1;
                    cur_clu   = it.first;
                    walk_len  = 13'd1;
                    r.status  = ST_VALID;
                end
                walk_results_due.push_back(r);
            end
            CMD_ADVANCE: begin
                if (!walk_open) begin
                    r.cluster = '0;
                    r.status  = ST_NO_CHAIN;
                end else begin
                    nxt = entry_of(cur_clu);
                    r.cluster = nxt;
                    if (nxt >= END_LOW) begin
                        walk_open = 1'b0;
                        r.status  = ST_END;
                    end else if (nxt >= lim || walk_len > lim) begin
                        walk_open = 1'b0;
                        r.status  = ST_ERROR;
                    end else begin
                        cur_clu  = nxt;
                        walk_len = walk_len + 13'd1;
                        r.status = ST_VALID;
                    end
                end
                walk_results_due.push_back(r);
            end
            default: ;
        endcase
        if (it.cmd != CMD_NOP)
            items_made++;
        pending.push_back(it);
    endtask

    task automatic send_load(logic [12:0] addr, logic [7:0] data);
        walk_item_t it;
        it = '{CMD_LOAD, addr, data, 12'($urandom)};
        walk_step(it);
    endtask

    task automatic send_start(logic [11:0] first);
        walk_item_t it;
        it = '{CMD_START, 13'($urandom), 8'($urandom), first};
        walk_step(it);
    endtask

    // table bytes of the open chain get written first so no unwritten byte is read
    task automatic send_adv();
        walk_item_t  it;
        int unsigned a;
        if (walk_open) begin
            for (int k = 0; k < 2; k++) begin
                a = (entry_at(cur_clu) + k) % STORE_BYTES;
                if (!fat_set[a])
                    send_load(13'(a), 8'($urandom));
            end
        end
        it = '{CMD_ADVANCE, 13'($urandom), 8'($urandom), 12'($urandom)};
        walk_step(it);
    endtask

    task automatic send_nop();
        walk_item_t it;
        it = '{CMD_NOP, 13'($urandom), 8'($urandom), 12'($urandom)};
        walk_step(it);
    endtask

    // write one table entry through byte loads, keeping the shared nibble
    task automatic set_entry(logic [11:0] c, logic [11:0] v);
        int unsigned at;
        int unsigned at1;
        logic [7:0]  old;
        at  = entry_at(c);
        at1 = (at + 1) % STORE_BYTES;
        if (c[0]) begin
            old = fat_set[at] ? fat_mem[at] : 8'($urandom);
            send_load(13'(at), {v[3:0], old[3:0]});
            send_load(13'(at1), v[11:4]);
        end else begin
            old = fat_set[at1] ? fat_mem[at1] : 8'($urandom);
            send_load(13'(at), v[7:0]);
            send_load(13'(at1), {old[7:4], v[11:8]});
        end
    endtask

    // build a short chain in the table, then start it and walk it
    task automatic walk_chain();
        int unsigned lim;
        int unsigned top;
        int unsigned len;
        int unsigned kind;
        int unsigned steps;
        logic [11:0] path [6];
        logic [11:0] tail;
        bit          loops;
        lim   = cluster_limit(tbl_bytes);
        top   = (lim == 0) ? 0 : ((lim - 1 > 12'hff7) ? 12'hff7 : lim - 1);
        len   = $urandom_range(1, 6);
        loops = 1'b0;
        for (int i = 0; i < 6; i++)
            path[i] = 12'($urandom_range(0, top));
        kind = $urandom_range(99);
        if (kind < 60) begin
            tail = END_LOW + 12'($urandom_range(0, 7));
        end else if (kind < 75 && lim <= 12'hff7) begin
            tail = 12'($urandom_range(lim, 12'hff7));
        end else if (kind < 88 && lim <= 30) begin
            tail  = path[0];
            loops = 1'b1;
        end else begin
            tail = 12'($urandom);
        end
        for (int i = 0; i < len - 1; i++)
            set_entry(path[i], path[i + 1]);
        set_entry(path[len - 1], tail);
        send_start(path[0]);
        steps = loops ? lim + 2 : len + $urandom_range(0, 2);
        repeat (steps) begin
            if ($urandom_range(19) == 0)
                send_load(13'($urandom), 8'($urandom));
            send_adv();
        end
    endtask

    // random traffic for one table size setting
    task automatic random_phase(int unsigned budget);
        int unsigned stop;
        int unsigned pick;
        stop = items_made + budget;
        while (items_made < stop) begin
            pick = $urandom_range(99);
            if (pick < 68) begin
                walk_chain();
            end else if (pick < 73) begin
                send_start(12'(cluster_limit(tbl_bytes)));
                send_adv();
            end else if (pick < 81) begin
                send_start(12'($urandom));
            end else if (pick < 88) begin
                send_adv();
            end else if (pick < 97) begin
                send_load(13'($urandom), 8'($urandom));
            end else begin
                send_nop();
            end
        end
    endtask

    // wait until every item went in and every result came back
    task automatic settle();
        while (pending.size() != 0 || s_tvalid || walk_results_due.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    task automatic write_table_size(logic [13:0] v);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge aclk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        tbl_bytes = v;
    endtask

    task automatic set_pace(int unsigned phase);
        if (phase < 4) begin
            send_gap_pct   = 18;
            sink_stall_pct = 51;
        end else if (phase < 7) begin
            send_gap_pct   = 51;
            sink_stall_pct = 18;
        end else begin
            send_gap_pct   = 0;
            sink_stall_pct = 0;
        end
    endtask

    task automatic note_mismatch(string what, walk_result_t want, walk_result_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected cluster %0d status %0d, got cluster %0d status %0d",
                     what, want.cluster, want.status, got.cluster, got.status);
    endtask

    // input side: launch the next pending transaction when the slot is free
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                launch_item = pending.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= {7'd0, launch_item.first, launch_item.data, launch_item.addr};
                s_tuser  <= launch_item.cmd;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side: random back-pressure and in-order compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
            if (m_tvalid && m_tready) begin
                got_res = '{m_tdata[11:0], m_tuser};
                if (walk_results_due.size() == 0) begin
                    note_mismatch("unexpected result", '0, got_res);
                end else begin
                    want_res = walk_results_due.pop_front();
                    if (got_res.cluster !== want_res.cluster || got_res.status !== want_res.status)
                        note_mismatch("wrong result", want_res, got_res);
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        logic [13:0] sizes [8];
        sizes = '{14'd20, 14'd8192, 14'd1, 14'd0, 14'd16383, 14'd300, 14'd7, 14'd6144};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset table size: no chain, extremes, a short chain to an end marker
        set_pace(0);
        send_adv();
        send_load(13'h1fff, 8'hff);
        send_load(13'h0000, 8'h00);
        set_entry(12'd5, 12'd4094);
        set_entry(12'd4094, 12'hfff);
        send_start(12'd5);
        send_adv();
        send_adv();
        send_adv();
        send_start(12'hfff);
        set_entry(12'hfff, END_LOW);
        send_adv();
        send_nop();
        settle();

        // tiny table: start at the count, beyond it, entry out of range, overlong loop
        set_pace(1);
        write_table_size(14'd3);
        send_start(12'd2);
        send_start(12'd3);
        set_entry(12'd0, 12'd2);
        send_start(12'd0);
        send_adv();
        set_entry(12'd1, 12'd1);
        send_start(12'd1);
        send_adv();
        send_adv();
        send_adv();
        settle();

        for (int p = 0; p < 8; p++) begin
            set_pace(p + 2);
            write_table_size(sizes[p]);
            random_phase(206);
            settle();
        end

        if (mismatches == 0 && walk_results_due.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // hard stop in case the block hangs
    initial begin
        #4000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
